>>> hw/rtl/rgb_lc_pkg.sv
// Shared types and fixed-point coefficients for the RGB 2x2 block to luma/chroma converter.
// No dependencies; imported by every module of the block.
package rgb_lc_pkg;

  localparam int FracBits = 23;

  // Luma weights, scaled by 2^FracBits; they sum to exactly 2^FracBits.
  localparam logic [30:0] LumaCoefR = 31'd2396625;
  localparam logic [30:0] LumaCoefG = 31'd4793251;
  localparam logic [30:0] LumaCoefB = 31'd1198732;

  // Chroma weights, applied to four-pixel channel totals.
  localparam logic signed [31:0] UCoefR = -32'sd299683;
  localparam logic signed [31:0] UCoefG = -32'sd599156;
  localparam logic signed [31:0] UCoefB =  32'sd898839;
  localparam logic signed [31:0] VCoefR =  32'sd748893;
  localparam logic signed [31:0] VCoefG = -32'sd599156;
  localparam logic signed [31:0] VCoefB = -32'sd149737;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } tot_t;

  typedef logic [30:0]        lprod_t;
  typedef logic signed [31:0] cprod_t;

  // Products of one block, index 2/1/0 = red/green/blue.
  typedef struct packed {
    lprod_t [3:0][2:0] luma;
    cprod_t [2:0]      u;
    cprod_t [2:0]      v;
  } prod_t;

endpackage

>>> hw/rtl/rgb_block_to_luma_chroma.sv
// Top level of the RGB 2x2 block to luma/chroma converter: input register and stage wiring.
// Depends on rgb_lc_pkg, rgb_lc_mul and rgb_lc_sum.
//
// Usage:
//   Present one 2x2 block of RGB24 pixels on the twelve colour ports and raise
//   start. The word is taken at the rising edge where start is high and busy
//   is low. busy is high only while rst is high, so outside reset a new word
//   may be taken on every clock cycle.
//   Each word gives exactly one result: four luma bytes and one shared U/V
//   pair. The result sits on the output ports for one cycle, flagged by done,
//   once the word has passed the input, multiplier and output registers.
//   Pipeline: input register with channel totals, multiplier register, then
//   add/shift/clamp into the output register. Throughput is one word per
//   cycle outside reset. The receiver cannot stall: results are never held,
//   so nothing back-pressures the pipe.
//   Reset (synchronous, active high) clears every valid bit; words in flight
//   are dropped and no word is taken while rst is high.
module rgb_block_to_luma_chroma (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_top_left,
  input  logic [7:0] green_top_left,
  input  logic [7:0] blue_top_left,
  input  logic [7:0] red_top_right,
  input  logic [7:0] green_top_right,
  input  logic [7:0] blue_top_right,
  input  logic [7:0] red_bottom_left,
  input  logic [7:0] green_bottom_left,
  input  logic [7:0] blue_bottom_left,
  input  logic [7:0] red_bottom_right,
  input  logic [7:0] green_bottom_right,
  input  logic [7:0] blue_bottom_right,
  output logic       done,
  output logic [7:0] luma_top_left,
  output logic [7:0] luma_top_right,
  output logic [7:0] luma_bottom_left,
  output logic [7:0] luma_bottom_right,
  output logic [7:0] chroma_u,
  output logic [7:0] chroma_v
);
  import rgb_lc_pkg::*;

  logic            accept;
  pix_t [3:0]      px_next;
  tot_t            tot_next;

  // Stage 1: captured pixels and channel totals.
  logic            v1;
  pix_t [3:0]      px;
  tot_t            tot;

  // Stage 2: products.
  logic            v2;
  prod_t           prod;

  // Stage 3: output register.
  logic [3:0][7:0] luma;

  // Hold off new words only while reset is asserted.
  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    px_next[0] = '{red: red_top_left,     green: green_top_left,     blue: blue_top_left};
    px_next[1] = '{red: red_top_right,    green: green_top_right,    blue: blue_top_right};
    px_next[2] = '{red: red_bottom_left,  green: green_bottom_left,  blue: blue_bottom_left};
    px_next[3] = '{red: red_bottom_right, green: green_bottom_right, blue: blue_bottom_right};
    // Per-channel totals over the four pixels, 0..1020 each.
    tot_next.red   = ({2'd0, px_next[0].red} + {2'd0, px_next[1].red})
                   + ({2'd0, px_next[2].red} + {2'd0, px_next[3].red});
    tot_next.green = ({2'd0, px_next[0].green} + {2'd0, px_next[1].green})
                   + ({2'd0, px_next[2].green} + {2'd0, px_next[3].green});
    tot_next.blue  = ({2'd0, px_next[0].blue} + {2'd0, px_next[1].blue})
                   + ({2'd0, px_next[2].blue} + {2'd0, px_next[3].blue});
  end

  // Capture the word; the valid bit alone sees reset.
  always_ff @(posedge clk) begin
    px  <= px_next;
    tot <= tot_next;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  rgb_lc_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .px        (px),
    .tot       (tot),
    .out_valid (v2),
    .prod      (prod)
  );

  rgb_lc_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .prod      (prod),
    .out_valid (done),
    .luma      (luma),
    .chroma_u  (chroma_u),
    .chroma_v  (chroma_v)
  );

  assign luma_top_left     = luma[0];
  assign luma_top_right    = luma[1];
  assign luma_bottom_left  = luma[2];
  assign luma_bottom_right = luma[3];

  // Every result traces back to an earlier accepted word.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result with no word taken three cycles before");

  // A word taken with no reset in flight always comes out.
  a_word_not_lost: assert property (@(posedge clk) disable iff (rst)
    ($past(accept, 3) && !$past(rst, 2) && !$past(rst, 1)) |-> done)
    else $error("word taken but no result three cycles later");

endmodule

>>> hw/rtl/rgb_lc_mul.sv
// Multiplier stage: all weight products of one block, registered.
// Depends on rgb_lc_pkg.
module rgb_lc_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  rgb_lc_pkg::pix_t [3:0] px,
  input  rgb_lc_pkg::tot_t       tot,
  output logic                   out_valid,
  output rgb_lc_pkg::prod_t      prod
);
  import rgb_lc_pkg::*;

  prod_t prod_next;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      prod_next.luma[p][2] = {23'd0, px[p].red}   * LumaCoefR;
      prod_next.luma[p][1] = {23'd0, px[p].green} * LumaCoefG;
      prod_next.luma[p][0] = {23'd0, px[p].blue}  * LumaCoefB;
    end
    prod_next.u[2] = $signed({22'd0, tot.red})   * UCoefR;
    prod_next.u[1] = $signed({22'd0, tot.green}) * UCoefG;
    prod_next.u[0] = $signed({22'd0, tot.blue})  * UCoefB;
    prod_next.v[2] = $signed({22'd0, tot.red})   * VCoefR;
    prod_next.v[1] = $signed({22'd0, tot.green}) * VCoefG;
    prod_next.v[0] = $signed({22'd0, tot.blue})  * VCoefB;
  end

  // Payload needs no reset; only the valid bit is cleared.
  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

>>> hw/rtl/rgb_lc_sum.sv
// Accumulate stage: add products, drop the fraction, clamp and register the result.
// Depends on rgb_lc_pkg.
module rgb_lc_sum (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rgb_lc_pkg::prod_t prod,
  output logic              out_valid,
  output logic [3:0][7:0]   luma,
  output logic [7:0]        chroma_u,
  output logic [7:0]        chroma_v
);
  import rgb_lc_pkg::*;

  logic [3:0][31:0] lsum;
  logic [3:0][7:0]  luma_next;
  cprod_t           usum;
  cprod_t           vsum;
  logic [7:0]       chroma_u_next;
  logic [7:0]       chroma_v_next;

  // Floor of the signed value over 2^FracBits, clamp to -128..127, add 128.
  function automatic logic [7:0] chroma_clamp(input cprod_t acc);
    logic signed [8:0] q;
    q = acc[31:FracBits];
    if (q > 9'sd127) begin
      chroma_clamp = 8'hff;
    end else if (q < -9'sd128) begin
      chroma_clamp = 8'h00;
    end else begin
      chroma_clamp = {~q[7], q[6:0]};
    end
  endfunction

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      lsum[p] = {1'b0, prod.luma[p][2]} + {1'b0, prod.luma[p][1]}
              + {1'b0, prod.luma[p][0]};
      luma_next[p] = (lsum[p][31:FracBits] > 9'd255) ? 8'hff : lsum[p][FracBits+7:FracBits];
    end
    usum = prod.u[2] + prod.u[1] + prod.u[0];
    vsum = prod.v[2] + prod.v[1] + prod.v[0];
    chroma_u_next = chroma_clamp(usum);
    chroma_v_next = chroma_clamp(vsum);
  end

  always_ff @(posedge clk) begin
    luma     <= luma_next;
    chroma_u <= chroma_u_next;
    chroma_v <= chroma_v_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

>>> bench/testbench.sv
// Self-checking bench for rgb_block_to_luma_chroma: directed table, then random 2x2 blocks.
// Depends on the RTL top level, not on rgb_lc_pkg; expected words come from an
// independent fixed-point predictor, but for the five typed-in directed rows.
module testbench;

  // Own copy of the fixed-point weights.
  // Kept apart from the package so that a wrong coefficient there shows up.
  localparam longint LumR = 2396625;
  localparam longint LumG = 4793251;
  localparam longint LumB = 1198732;
  localparam longint CbR  = -299683;
  localparam longint CbG  = -599156;
  localparam longint CbB  = 898839;
  localparam longint CrR  = 748893;
  localparam longint CrG  = -599156;
  localparam longint CrB  = -149737;
  localparam int     Frac = 23;
  localparam int     Bias = 128;

  localparam int Latency  = 3;
  localparam int DirRows  = 16;
  localparam int Phases   = 4;
  localparam int PerPhase = 412;

  // Directed blocks.
  // Bytes run from the top-left pixel to the bottom-right pixel, each pixel as R, G, B.
  // Result words hold luma TL, TR, BL, BR, then U and V.
  localparam logic [95:0] DirPix [DirRows] = '{
    96'h000000_000000_000000_000000,   // all black
    96'hFFFFFF_FFFFFF_FFFFFF_FFFFFF,   // all white
    96'hFF0000_FF0000_FF0000_FF0000,   // pure red
    96'h00FF00_00FF00_00FF00_00FF00,   // pure green
    96'h0000FF_0000FF_0000FF_0000FF,   // pure blue
    96'hFFFFFF_000000_000000_FFFFFF,   // checkerboard
    96'h000000_FFFFFF_FFFFFF_000000,   // inverse checkerboard
    96'h555555_555555_555555_555555,
    96'hAAAAAA_AAAAAA_AAAAAA_AAAAAA,
    96'hFF0000_00FF00_0000FF_FFFFFF,   // a different primary in each of the first three pixels, white in the last
    96'hFFFF00_FFFF00_FFFF00_FFFF00,   // yellow: most negative U
    96'h00FFFF_00FFFF_00FFFF_00FFFF,   // cyan: most negative V
    96'h808080_7F7F7F_808080_7F7F7F,
    96'h010101_FEFEFE_010101_FEFEFE,
    96'hFF00FF_000000_000000_000000,   // one lit corner
    96'h123456_789ABC_DEF012_345678
  };
  // The first five rows are read straight off the formulae; the others go to the predictor.
  localparam bit DirTyped [DirRows] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam logic [47:0] DirWant [DirRows] = '{
    48'h00000000_8080,
    48'hFFFFFFFF_8080,
    48'h48484848_5BDB,
    48'h91919191_3737,
    48'h24242424_ED6D,
    48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0
  };
  localparam int IdlePct [Phases] = '{0, 45, 13, 0};

  logic       clk;
  logic       rst                = 1'b1;
  logic       start              = 1'b0;
  logic       busy;
  logic [7:0] red_top_left       = 8'h00;
  logic [7:0] green_top_left     = 8'h00;
  logic [7:0] blue_top_left      = 8'h00;
  logic [7:0] red_top_right      = 8'h00;
  logic [7:0] green_top_right    = 8'h00;
  logic [7:0] blue_top_right     = 8'h00;
  logic [7:0] red_bottom_left    = 8'h00;
  logic [7:0] green_bottom_left  = 8'h00;
  logic [7:0] blue_bottom_left   = 8'h00;
  logic [7:0] red_bottom_right   = 8'h00;
  logic [7:0] green_bottom_right = 8'h00;
  logic [7:0] blue_bottom_right  = 8'h00;
  logic       done;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;

  // Travels alongside each word: a typed-in expectation for the directed rows.
  logic        word_typed = 1'b0;
  logic [47:0] word_want  = 48'h0;

  logic [47:0] yuv_due [$];
  int          mismatches = 0;
  string       field_name [6] = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                                  "luma_bottom_right", "chroma_u", "chroma_v"};

  rgb_block_to_luma_chroma uut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .red_top_left       (red_top_left),
    .green_top_left     (green_top_left),
    .blue_top_left      (blue_top_left),
    .red_top_right      (red_top_right),
    .green_top_right    (green_top_right),
    .blue_top_right     (blue_top_right),
    .red_bottom_left    (red_bottom_left),
    .green_bottom_left  (green_bottom_left),
    .blue_bottom_left   (blue_bottom_left),
    .red_bottom_right   (red_bottom_right),
    .green_bottom_right (green_bottom_right),
    .blue_bottom_right  (blue_bottom_right),
    .done               (done),
    .luma_top_left      (luma_top_left),
    .luma_top_right     (luma_top_right),
    .luma_bottom_left   (luma_bottom_left),
    .luma_bottom_right  (luma_bottom_right),
    .chroma_u           (chroma_u),
    .chroma_v           (chroma_v)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Predict the result word of one block.
  // >>> on a signed longint floors, which matches the rounding of the chroma shift.
  function automatic logic [47:0] yuv_of(logic [95:0] pix);
    longint      tot [3];
    longint      px;
    longint      acc;
    longint      q;
    logic [47:0] res;
    longint      wt [3];
    wt = '{LumR, LumG, LumB};
    tot = '{0, 0, 0};
    for (int p = 0; p < 4; p++) begin
      acc = 0;
      for (int ch = 0; ch < 3; ch++) begin
        px = pix[95 - 8 * (3 * p + ch) -: 8];
        tot[ch] += px;
        acc += wt[ch] * px;
      end
      q = clamp(acc >>> Frac, 0, 255);
      res[47 - 8 * p -: 8] = q[7:0];
    end
    acc = CbR * tot[0] + CbG * tot[1] + CbB * tot[2];
    q = clamp(acc >>> Frac, -128, 127) + Bias;
    res[15:8] = q[7:0];
    acc = CrR * tot[0] + CrG * tot[1] + CrB * tot[2];
    q = clamp(acc >>> Frac, -128, 127) + Bias;
    res[7:0] = q[7:0];
    return res;
  endfunction

  // Random block content: mostly full-range bytes, plus extremes, uniform
  // colours and bytes on the bit-pattern edges.
  function automatic logic [95:0] random_block();
    logic [95:0] pix;
    logic [23:0] colour;
    logic [7:0]  edges [6];
    int          mode;
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    mode = $urandom_range(9);
    pix = {$urandom, $urandom, $urandom};
    if (mode == 6 || mode == 7) begin
      for (int k = 0; k < 12; k++) pix[8 * k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (mode == 8) begin
      colour = 24'($urandom);
      pix = {colour, colour, colour, colour};
    end else if (mode == 9) begin
      for (int k = 0; k < 12; k++) pix[8 * k +: 8] = edges[$urandom_range(5)];
    end
    return pix;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Offer one word and hold it until the block takes it.
  // Idle cycles ahead of the word are drawn with the given chance; when none are
  // drawn start stays high straight on from the previous word.
  task automatic send_word(logic [95:0] pix, bit typed, logic [47:0] want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    red_top_left       <= pix[95:88];
    green_top_left     <= pix[87:80];
    blue_top_left      <= pix[79:72];
    red_top_right      <= pix[71:64];
    green_top_right    <= pix[63:56];
    blue_top_right     <= pix[55:48];
    red_bottom_left    <= pix[47:40];
    green_bottom_left  <= pix[39:32];
    blue_bottom_left   <= pix[31:24];
    red_bottom_right   <= pix[23:16];
    green_bottom_right <= pix[15:8];
    blue_bottom_right  <= pix[7:0];
    word_typed         <= typed;
    word_want          <= want;
    // Values read just after the edge are the ones the block sampled at it.
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Monitor: log each accepted word and check each strobed result.
  // Everything here reads values from before the edge, so the order against
  // the driver and the RTL within a time step does not matter.
  always @(posedge clk) begin
    logic [47:0] got;
    logic [47:0] want;
    if (done) begin
      got = {luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
             chroma_u, chroma_v};
      if (yuv_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no word outstanding", got));
      end else begin
        want = yuv_due.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[47 - 8 * i -: 8] !== want[47 - 8 * i -: 8])
            report_mismatch($sformatf("%s got %h want %h", field_name[i],
                                      got[47 - 8 * i -: 8], want[47 - 8 * i -: 8]));
        end
      end
    end
    if (start && !busy) begin
      if (word_typed) begin
        yuv_due.push_back(word_want);
      end else begin
        yuv_due.push_back(yuv_of({red_top_left, green_top_left, blue_top_left,
                                  red_top_right, green_top_right, blue_top_right,
                                  red_bottom_left, green_bottom_left, blue_bottom_left,
                                  red_bottom_right, green_bottom_right, blue_bottom_right}));
      end
    end
  end

  // Stimulus: reset once, walk the directed table back to back, then run the
  // random phases with the idle chances in IdlePct on the sending side.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DirRows; i++) send_word(DirPix[i], DirTyped[i], DirWant[i], 0);
    for (int ph = 0; ph < Phases; ph++) begin
      for (int n = 0; n < PerPhase; n++) send_word(random_block(), 1'b0, 48'h0, IdlePct[ph]);
    end
    start <= 1'b0;
    @(posedge clk);
    // Drain the pipe, then keep watching for any stray strobe.
    while (yuv_due.size() != 0) @(posedge clk);
    repeat (Latency + 3) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: stops the run as failed if it never finishes.
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
